[rtl/mwm_pkg.sv]
// Shared types and constants for the mecanum wheel mixer.
`timescale 1ns / 1ps
package mwm_pkg;

  // Fraction bits of the Q format; ONE = 2^FRAC_BITS stands for 1.0.
  localparam int unsigned FRAC_BITS = 14;
  // Quotient bits: one integer bit plus the fraction bits.
  localparam int unsigned QW        = FRAC_BITS + 1;
  localparam int unsigned WHEELS    = 4;
  localparam int unsigned CMD_W     = 16;
  localparam int unsigned SPD_W     = 16;
  // Three 16-bit commands summed need 18 signed bits; magnitudes need 17.
  localparam int unsigned SUM_W     = 18;
  localparam int unsigned MAG_W     = 17;
  localparam logic [31:0] ONE_Q     = 32'd1 << FRAC_BITS;
  // Mix stage, magnitude stage, QW divider steps and the output register.
  localparam int unsigned LATENCY   = QW + 3;

  // Wheel lane order.
  localparam int unsigned FR = 0;
  localparam int unsigned FL = 1;
  localparam int unsigned BR = 2;
  localparam int unsigned BL = 3;

  typedef struct packed {
    logic signed [CMD_W-1:0] forward_cmd;
    logic signed [CMD_W-1:0] right_cmd;
    logic signed [CMD_W-1:0] turn_cmd;
  } mwm_cmd_t;

  typedef struct packed {
    logic signed [SPD_W-1:0] front_right_speed;
    logic signed [SPD_W-1:0] front_left_speed;
    logic signed [SPD_W-1:0] back_right_speed;
    logic signed [SPD_W-1:0] back_left_speed;
    logic                    was_scaled;
  } mwm_speed_t;

  // Divider pipeline payload, one lane per wheel.
  typedef struct packed {
    logic                              scaled;
    logic [MAG_W-1:0]                  top;
    logic [WHEELS-1:0]                 neg;
    logic [WHEELS-1:0][SUM_W-1:0]      rem;
    logic [WHEELS-1:0][QW-1:0]         quo;
    logic [WHEELS-1:0][SPD_W-1:0]      raw;
  } mwm_div_t;

endpackage

[rtl/mecanum_wheel_mixer_core.sv]
// Path from start_i to valid_o: mix stage, magnitude stage, divider steps, output register.
// Throughput: one item per cycle; busy_o stays low, as every stage advances each cycle.
// The depth is set by the normalizing divider, one quotient bit per pipeline stage.
// Reset clears all valid bits at once; payload registers are not reset.
// Each result shows on result_o for one cycle with valid_o high and is not held.
`timescale 1ns / 1ps
module mecanum_wheel_mixer_core import mwm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  output logic       busy_o,
  input  mwm_cmd_t   cmd_i,
  output logic       valid_o,
  output mwm_speed_t result_o
);

  logic     accept;
  logic     chain_v [QW+1];
  mwm_div_t chain_d [QW+1];

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  mwm_mix u_mix (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (accept),
    .cmd_i   (cmd_i),
    .valid_o (chain_v[0]),
    .div_o   (chain_d[0])
  );

  for (genvar k = 0; k < QW; k++) begin : g_div
    mwm_div_step u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (chain_v[k]),
      .div_i   (chain_d[k]),
      .valid_o (chain_v[k+1]),
      .div_o   (chain_d[k+1])
    );
  end

  mwm_out u_out (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (chain_v[QW]),
    .div_i    (chain_d[QW]),
    .valid_o  (valid_o),
    .result_o (result_o)
  );

endmodule

[rtl/mwm_mix.sv]
// Wheel mixing stage followed by the magnitude and largest-magnitude stage.
`timescale 1ns / 1ps
module mwm_mix import mwm_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     valid_i,
  input  mwm_cmd_t cmd_i,
  output logic     valid_o,
  output mwm_div_t div_o
);

  logic signed [SUM_W-1:0]      f, r, c;
  logic [WHEELS-1:0][SUM_W-1:0] w_d, w_q;
  logic                         valid_a_q;

  logic [WHEELS-1:0][SUM_W-1:0] neg_w;
  logic [WHEELS-1:0][MAG_W-1:0] mag;
  logic [MAG_W-1:0]             max01, max23, top;
  mwm_div_t                     div_d, div_q;
  logic                         valid_b_q;

  assign f = SUM_W'(cmd_i.forward_cmd);
  assign r = SUM_W'(cmd_i.right_cmd);
  assign c = SUM_W'(cmd_i.turn_cmd);

  always_comb begin
    w_d[FR] = -(f + r + c);
    w_d[FL] = f - r - c;
    w_d[BR] = -(f - r + c);
    w_d[BL] = f + r - c;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_a_q <= 1'b0;
      valid_b_q <= 1'b0;
    end else begin
      valid_a_q <= valid_i;
      valid_b_q <= valid_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    w_q   <= w_d;
    div_q <= div_d;
  end

  always_comb begin
    for (int i = 0; i < WHEELS; i++) begin
      neg_w[i] = -w_q[i];
      mag[i]   = w_q[i][SUM_W-1] ? neg_w[i][MAG_W-1:0] : w_q[i][MAG_W-1:0];
    end
    max01 = (mag[FR] > mag[FL]) ? mag[FR] : mag[FL];
    max23 = (mag[BR] > mag[BL]) ? mag[BR] : mag[BL];
    top   = (max01 > max23) ? max01 : max23;

    div_d.scaled = 32'(top) > ONE_Q;
    div_d.top    = top;
    for (int i = 0; i < WHEELS; i++) begin
      div_d.neg[i] = w_q[i][SUM_W-1];
      div_d.rem[i] = SUM_W'(mag[i]);
      div_d.quo[i] = '0;
      div_d.raw[i] = w_q[i][SPD_W-1:0];
    end
  end

  assign valid_o = valid_b_q;
  assign div_o   = div_q;

endmodule

[rtl/mwm_div_step.sv]
// One restoring division step for all four wheel lanes, registered.
`timescale 1ns / 1ps
module mwm_div_step import mwm_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     valid_i,
  input  mwm_div_t div_i,
  output logic     valid_o,
  output mwm_div_t div_o
);

  logic [WHEELS-1:0] ge;
  mwm_div_t          div_d, div_q;
  logic              valid_q;

  // Compare and subtract, then shift the partial remainder for the next bit.
  // The remainder is below the divisor after the subtraction, so the shift never overflows.
  always_comb begin
    div_d = div_i;
    for (int i = 0; i < WHEELS; i++) begin
      ge[i]        = div_i.rem[i] >= SUM_W'(div_i.top);
      div_d.rem[i] = SUM_W'((div_i.rem[i] - (ge[i] ? SUM_W'(div_i.top) : SUM_W'(0))) << 1);
      div_d.quo[i] = {div_i.quo[i][QW-2:0], ge[i]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    div_q <= div_d;
  end

  assign valid_o = valid_q;
  assign div_o   = div_q;

endmodule

[rtl/mwm_out.sv]
// Sign restore, pass-through select and the result register.
`timescale 1ns / 1ps
module mwm_out import mwm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  input  mwm_div_t   div_i,
  output logic       valid_o,
  output mwm_speed_t result_o
);

  logic [WHEELS-1:0][31:0]      mag32, sgn32;
  logic [WHEELS-1:0][SPD_W-1:0] spd;
  mwm_speed_t                   result_d, result_q;
  logic                         valid_q;

  always_comb begin
    for (int i = 0; i < WHEELS; i++) begin
      mag32[i] = 32'(div_i.quo[i]);
      sgn32[i] = div_i.neg[i] ? -mag32[i] : mag32[i];
      spd[i]   = div_i.scaled ? sgn32[i][SPD_W-1:0] : div_i.raw[i];
    end
    result_d.front_right_speed = spd[FR];
    result_d.front_left_speed  = spd[FL];
    result_d.back_right_speed  = spd[BR];
    result_d.back_left_speed   = spd[BL];
    result_d.was_scaled        = div_i.scaled;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    result_q <= result_d;
  end

  assign valid_o  = valid_q;
  assign result_o = result_q;

endmodule

[rtl/mwm_checker.sv]
// Port-level checks on the mixer's timing and result range, bound to the top level.
`timescale 1ns / 1ps
module mwm_checker import mwm_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start_i,
  input logic       busy_o,
  input logic       valid_o,
  input mwm_speed_t result_o
);

  localparam int ONE_I  = 1 << FRAC_BITS;
  // Range checks only make sense while ONE fits the signed output width.
  localparam bit NARROW = FRAC_BITS >= SPD_W - 1;

  // Every accepted item yields its result after the fixed latency.
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##LATENCY valid_o)
    else $error("accepted item produced no result at the expected latency");

  // No result appears without an item accepted the latency earlier.
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(start_i && !busy_o, LATENCY))
    else $error("result without a matching accepted item");

  // All four speeds stay within plus or minus one.
  a_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> NARROW ||
      (result_o.front_right_speed >= -ONE_I && result_o.front_right_speed <= ONE_I &&
       result_o.front_left_speed  >= -ONE_I && result_o.front_left_speed  <= ONE_I &&
       result_o.back_right_speed  >= -ONE_I && result_o.back_right_speed  <= ONE_I &&
       result_o.back_left_speed   >= -ONE_I && result_o.back_left_speed   <= ONE_I))
    else $error("wheel speed outside the normalized range");

  // After scaling, the wheel with the largest magnitude lands exactly on plus or minus one.
  a_scaled_hits_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && result_o.was_scaled) |-> NARROW ||
      result_o.front_right_speed == ONE_I || result_o.front_right_speed == -ONE_I ||
      result_o.front_left_speed  == ONE_I || result_o.front_left_speed  == -ONE_I ||
      result_o.back_right_speed  == ONE_I || result_o.back_right_speed  == -ONE_I ||
      result_o.back_left_speed   == ONE_I || result_o.back_left_speed   == -ONE_I)
    else $error("scaled result has no wheel at full magnitude");

endmodule

bind mecanum_wheel_mixer_core mwm_checker u_mwm_checker (.*);
